// ----- src/b64se_pkg.sv -----
// Shared types, constants and the alphabet lookup for the Base64 encoder.
`timescale 1ns / 1ps

package b64se_pkg;

    localparam int unsigned GroupBits = 24;
    localparam int unsigned QueueDepth = 2;
    localparam int unsigned QueuePtrBits = $clog2(QueueDepth);
    localparam logic [6:0] PAD_CHAR = 7'h3D;

    // one 24-bit group on its way from the front end to the serialiser
    typedef struct packed {
        logic [GroupBits-1:0] bits;
        logic [1:0]           have;   // bytes in the group: 1, 2 or 3
        logic                 last;   // group closes the string
    } group_t;

    function automatic logic [6:0] b64_char(input logic [5:0] idx);
        logic [6:0] ch;
        begin
            if (idx < 6'd26)
            begin
                ch = 7'h41 + {1'b0, idx};
            end
            else if (idx < 6'd52)
            begin
                ch = 7'h61 + {1'b0, idx - 6'd26};
            end
            else if (idx < 6'd62)
            begin
                ch = 7'h30 + {1'b0, idx - 6'd52};
            end
            else if (idx == 6'd62)
            begin
                ch = 7'h2B;
            end
            else
            begin
                ch = 7'h2F;
            end
            return ch;
        end
    endfunction

endpackage

// ----- src/b64se_front.sv -----
// Front end: gathers input bytes into groups of three and emits closed groups.
`timescale 1ns / 1ps

module b64se_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [7:0]        data_byte,
    input  logic              end_of_string,
    output logic              grp_wr,
    output b64se_pkg::group_t grp,
    input  logic              grp_full
);
    import b64se_pkg::*;

    logic [15:0] bytes_reg;
    logic [15:0] bytes_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        accept;
    logic [1:0]  have;
    logic        emit;

    assign full   = grp_full;
    assign accept = push && !grp_full;
    assign have   = count_reg + 2'd1;
    assign emit   = (count_reg == 2'd2) || end_of_string;
    assign grp_wr = accept && emit;

    always_comb
    begin
        grp.have = have;
        grp.last = end_of_string;
        case (count_reg)
            2'd0:    grp.bits = {data_byte, 16'h0000};
            2'd1:    grp.bits = {bytes_reg[15:8], data_byte, 8'h00};
            default: grp.bits = {bytes_reg, data_byte};
        endcase
    end

    always_comb
    begin
        bytes_next = bytes_reg;
        count_next = count_reg;
        if (accept)
        begin
            if (emit)
            begin
                bytes_next = 16'h0000;
                count_next = 2'd0;
            end
            else
            begin
                if (count_reg == 2'd0)
                begin
                    bytes_next = {data_byte, 8'h00};
                end
                else
                begin
                    bytes_next = {bytes_reg[15:8], data_byte};
                end
                count_next = have;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_reg <= 16'h0000;
            count_reg <= 2'd0;
        end
        else
        begin
            bytes_reg <= bytes_next;
            count_reg <= count_next;
        end
    end

endmodule

// ----- src/b64se_queue.sv -----
// Short group queue between the front end and the character serialiser.
`timescale 1ns / 1ps

module b64se_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr,
    input  b64se_pkg::group_t wr_data,
    output logic              q_full,
    input  logic              rd,
    output logic              rd_valid,
    output b64se_pkg::group_t rd_data
);
    import b64se_pkg::*;

    localparam int unsigned CountBits = $clog2(QueueDepth + 1);

    group_t                  slot_reg [QueueDepth];
    logic [QueuePtrBits-1:0] wr_ptr_reg;
    logic [QueuePtrBits-1:0] wr_ptr_next;
    logic [QueuePtrBits-1:0] rd_ptr_reg;
    logic [QueuePtrBits-1:0] rd_ptr_next;
    logic [CountBits-1:0]    count_reg;
    logic [CountBits-1:0]    count_next;
    logic                    do_wr;
    logic                    do_rd;

    assign q_full   = (count_reg == CountBits'(QueueDepth));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = slot_reg[rd_ptr_reg];
    assign do_wr    = wr && !q_full;
    assign do_rd    = rd && rd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == QueuePtrBits'(QueueDepth - 1)) ? '0
                                                                          : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == QueuePtrBits'(QueueDepth - 1)) ? '0
                                                                          : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- src/b64se_back.sv -----
// Back end: each group to four chars in an output register, one per cycle unless stalled.
`timescale 1ns / 1ps

module b64se_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              grp_valid,
    input  b64se_pkg::group_t grp,
    output logic              grp_rd,
    output logic              empty,
    input  logic              pop,
    output logic [6:0]        code_char,
    output logic              final_char
);
    import b64se_pkg::*;

    group_t     cur_reg;
    group_t     cur_next;
    logic       busy_reg;
    logic       busy_next;
    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [6:0] out_char_reg;
    logic [6:0] out_char_next;
    logic       out_final_reg;
    logic       out_final_next;
    logic       out_load;
    logic       take;
    logic       done;
    logic [6:0] ch;

    assign empty      = !out_valid_reg;
    assign code_char  = out_char_reg;
    assign final_char = out_final_reg;

    // output register frees up when empty or being popped this cycle
    assign out_load = !out_valid_reg || pop;
    assign take     = busy_reg && out_load;
    assign done     = take && (idx_reg == 2'd3);
    assign grp_rd   = !busy_reg || done;

    always_comb
    begin
        case (idx_reg)
            2'd0:    ch = b64_char(cur_reg.bits[23:18]);
            2'd1:    ch = b64_char(cur_reg.bits[17:12]);
            2'd2:    ch = (cur_reg.have >= 2'd2) ? b64_char(cur_reg.bits[11:6]) : PAD_CHAR;
            default: ch = (cur_reg.have == 2'd3) ? b64_char(cur_reg.bits[5:0]) : PAD_CHAR;
        endcase
    end

    always_comb
    begin
        cur_next       = cur_reg;
        busy_next      = busy_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_final_next = out_final_reg;
        if (out_load)
        begin
            out_valid_next = busy_reg;
        end
        if (take)
        begin
            out_char_next  = ch;
            out_final_next = cur_reg.last && (idx_reg == 2'd3);
            idx_next       = idx_reg + 2'd1;
            if (done)
            begin
                busy_next = 1'b0;
            end
        end
        if (grp_rd && grp_valid)
        begin
            cur_next  = grp;
            busy_next = 1'b1;
            idx_next  = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        out_char_reg  <= out_char_next;
        out_final_reg <= out_final_next;
    end

endmodule

// ----- src/base64_stream_encoder.sv -----
// Top level of the streaming Base64 encoder.
//
// Input side is a queue: a byte word (data_byte, end_of_string) is taken on
// a clock edge with push high and full low. end_of_string closes the string.
// Output side is a queue too: while empty is low, code_char and final_char
// show the oldest character; pop high on an edge takes it.
// Every third byte, or any byte with end_of_string, closes a group that gives
// four characters ('=' padded on a short group); final_char marks the last
// character of a string. A byte that closes nothing gives no output.
// A closing byte's group passes through the group queue and the back end's
// group register before its first character reaches the output register.
// The serialiser gives one character per cycle while the output is empty or
// popped; input only stalls once the two-entry group queue is full.
// When pop is held low, characters stay put, the queue fills and full rises;
// no word is dropped. Reset clears pending bytes, the queue and the output.
`timescale 1ns / 1ps

module base64_stream_encoder
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] data_byte,
    input  logic       end_of_string,
    output logic       empty,
    input  logic       pop,
    output logic [6:0] code_char,
    output logic       final_char
);
    import b64se_pkg::*;

    group_t wr_grp;
    group_t rd_grp;
    logic   grp_wr;
    logic   q_full;
    logic   q_rd;
    logic   q_valid;

    b64se_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .data_byte     (data_byte),
        .end_of_string (end_of_string),
        .grp_wr        (grp_wr),
        .grp           (wr_grp),
        .grp_full      (q_full)
    );

    b64se_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (grp_wr),
        .wr_data  (wr_grp),
        .q_full   (q_full),
        .rd       (q_rd),
        .rd_valid (q_valid),
        .rd_data  (rd_grp)
    );

    b64se_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .grp_valid  (q_valid),
        .grp        (rd_grp),
        .grp_rd     (q_rd),
        .empty      (empty),
        .pop        (pop),
        .code_char  (code_char),
        .final_char (final_char)
    );

endmodule
